FILE: hw/rtl/knn_pkg.sv
// Shared constants, widths and the sequencer state type for the k-NN vote unit.
// No dependencies; imported by every module of the unit.
package knn_pkg;

    localparam int MAX_K       = 8;
    localparam int MAX_CLASSES = 64;

    localparam int SIM_W     = 16;
    localparam int LBL_W     = 6;
    localparam int K_W       = 4;
    localparam int NCLS_W    = 7;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int SLOT_W    = $clog2(MAX_K);
    localparam int SUM_W     = SIM_W + $clog2(MAX_K);
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam logic [K_W-1:0]    K_RESET    = K_W'(3);
    localparam logic [NCLS_W-1:0] NCLS_RESET = NCLS_W'(64);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_K_IN_USE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_TALLY,
        S_DIV
    } t_state;

endpackage

FILE: hw/rtl/knn_div.sv
// Bit-serial restoring divider: signed slot-score sum by the neighbour count.
// Quotient truncates toward zero. Depends on knn_pkg.
module knn_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [knn_pkg::SUM_W-1:0]  i_dividend,
    input  logic        [knn_pkg::K_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic signed [knn_pkg::SIM_W-1:0]  o_quotient
);
    import knn_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_q;
    logic [K_W-1:0]       r_rem;
    logic [K_W-1:0]       r_div;

    logic [K_W:0]         rem_sh;
    logic                 fits;
    logic [K_W:0]         rem_sub;
    logic [SUM_W-1:0]     mag;
    logic [SUM_W-1:0]     q_signed;

    assign mag      = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
    assign rem_sh   = {r_rem, r_q[SUM_W-1]};
    assign fits     = rem_sh >= {1'b0, r_div};
    assign rem_sub  = rem_sh - {1'b0, r_div};
    assign q_signed = r_neg ? (~r_q + 1'b1) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_q   <= mag;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits K_W bits
            r_rem <= fits ? rem_sub[K_W-1:0] : rem_sh[K_W-1:0];
            r_q   <= {r_q[SUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = q_signed[SIM_W-1:0];

endmodule

FILE: hw/rtl/knn_top_k_majority_vote_unit.sv
// k-NN top-K majority vote. A non-final request goes from acceptance through S_SCAN, which
// finds the lowest slot with the shared compare, and S_UPDATE back to S_IDLE for the next one.
// A final request goes on through S_TALLY and the S_DIV divider: its result becomes valid once
// the divider is done, later while an earlier result still waits, and ready returns then.
// Synchronous active-low reset restores k_in_use=3, num_classes=64 and clears all slots.
// The result register frees the input side; a new request is taken while a result waits.
module knn_top_k_majority_vote_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [knn_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [knn_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [knn_pkg::SIM_W-1:0]     i_similarity,
    input  logic [knn_pkg::LBL_W-1:0]            i_class_label,
    input  logic                                 i_last_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [knn_pkg::LBL_W-1:0]            o_winning_label,
    output logic [knn_pkg::K_W-1:0]              o_vote_count,
    output logic signed [knn_pkg::SIM_W-1:0]     o_mean_similarity
);
    import knn_pkg::*;

    t_state r_state, n_state;

    logic [K_W-1:0]    r_k_in_use;
    logic [NCLS_W-1:0] r_num_classes;

    logic signed [SIM_W-1:0] r_score [MAX_K];
    logic [LBL_W-1:0]        r_class [MAX_K];
    logic [MAX_K-1:0]        r_filled;

    logic signed [SIM_W-1:0] r_sim;
    logic [LBL_W-1:0]        r_lbl;
    logic                    r_last;
    logic [K_W-1:0]          r_k;
    logic [K_W-1:0]          r_idx;
    logic [SLOT_W-1:0]       r_low;
    logic signed [SIM_W-1:0] r_min;
    logic signed [SUM_W-1:0] r_sum;
    logic [LBL_W-1:0]        r_best_lbl;
    logic [K_W-1:0]          r_best_cnt;

    logic                    r_out_valid;
    logic [LBL_W-1:0]        r_out_lbl;
    logic [K_W-1:0]          r_out_cnt;
    logic signed [SIM_W-1:0] r_out_mean;

    logic [K_W-1:0]          k_eff;
    logic [NCLS_W-1:0]       ncls_eff;
    logic signed [SIM_W-1:0] rd_score;
    logic [LBL_W-1:0]        rd_class;
    logic                    rd_filled;
    logic [K_W-1:0]          cnt;
    logic                    votes;
    logic                    better;
    logic                    in_acc;
    logic                    scan_more;
    logic                    div_start;
    logic                    div_done;
    logic signed [SIM_W-1:0] div_q;
    logic                    load_out;

    assign k_eff = (r_k_in_use == '0) ? K_W'(1) :
                   (r_k_in_use > K_W'(MAX_K)) ? K_W'(MAX_K) : r_k_in_use;
    assign ncls_eff = (r_num_classes == '0) ? NCLS_W'(1) :
                      (r_num_classes > NCLS_W'(MAX_CLASSES)) ? NCLS_W'(MAX_CLASSES)
                                                             : r_num_classes;

    assign rd_score  = r_score[r_idx[SLOT_W-1:0]];
    assign rd_class  = r_class[r_idx[SLOT_W-1:0]];
    assign rd_filled = r_filled[r_idx[SLOT_W-1:0]];
    assign scan_more = r_idx < r_k;

    // votes for the slot under the pointer: every live filled slot with the same class
    always_comb begin
        cnt = '0;
        for (int j = 0; j < MAX_K; j++) begin
            if (K_W'(j) < r_k && r_filled[j] && r_class[j] == rd_class) begin
                cnt = cnt + 1'b1;
            end
        end
    end

    assign votes  = rd_filled && ({1'b0, rd_class} < ncls_eff);
    assign better = votes && ((cnt > r_best_cnt) ||
                              (cnt == r_best_cnt && rd_class < r_best_lbl));

    assign in_acc   = i_in_valid && o_in_ready;
    assign load_out = (r_state == S_DIV) && div_done && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!scan_more) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = r_last ? S_TALLY : S_IDLE;
            end
            S_TALLY: begin
                if (!scan_more) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_in_use    <= K_RESET;
            r_num_classes <= NCLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_K_IN_USE:    r_k_in_use    <= i_cfg_data[K_W-1:0];
                CFG_NUM_CLASSES: r_num_classes <= i_cfg_data[NCLS_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture and sequencing registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_sim  <= i_similarity;
                    r_lbl  <= i_class_label;
                    r_last <= i_last_item;
                    r_k    <= k_eff;
                    r_idx  <= K_W'(1);
                    r_low  <= '0;
                    r_min  <= r_score[0];
                end
            end
            S_SCAN: begin
                if (scan_more) begin
                    if (rd_score < r_min) begin
                        r_low <= r_idx[SLOT_W-1:0];
                        r_min <= rd_score;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_UPDATE: begin
                r_idx      <= '0;
                r_sum      <= '0;
                r_best_lbl <= '0;
                r_best_cnt <= '0;
            end
            S_TALLY: begin
                if (scan_more) begin
                    r_sum <= r_sum + SUM_W'(rd_score);
                    if (better) begin
                        r_best_lbl <= rd_class;
                        r_best_cnt <= cnt;
                    end
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_DIV: ;
            default: ;
        endcase
    end

    // slot store: replace the lowest slot when the new score is higher, cleared on reset and when a result is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load_out) begin
            for (int i = 0; i < MAX_K; i++) begin
                r_score[i] <= '0;
                r_class[i] <= '0;
            end
            r_filled <= '0;
        end else if (r_state == S_UPDATE && r_sim > r_min) begin
            r_score[r_low]  <= r_sim;
            r_class[r_low]  <= r_lbl;
            r_filled[r_low] <= 1'b1;
        end
    end

    knn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_k),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_lbl  <= r_best_lbl;
            r_out_cnt  <= r_best_cnt;
            r_out_mean <= div_q;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_winning_label   = r_out_lbl;
    assign o_vote_count      = r_out_cnt;
    assign o_mean_similarity = r_out_mean;

`ifndef SYNTHESIS
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input ready held high after a request");

    a_slots_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_filled == '0))
        else $error("slots not cleared after a result");

    a_votes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_vote_count <= K_W'(MAX_K)))
        else $error("vote count above slot count");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> (r_state == S_DIV && !div_done))
        else $error("divider start out of sequence");
`endif

endmodule

FILE: tb/sv/knn_top_k_majority_vote_checker.sv
// Scoreboard for the k-NN top-K majority vote unit: keeps its own neighbour slots,
// predicts the vote result of every final request and compares it with the output channel.
// Depends on knn_pkg for widths, reset values and register indexes.
module knn_top_k_majority_vote_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [knn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [knn_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic signed [knn_pkg::SIM_W-1:0]  i_similarity,
    input  logic [knn_pkg::LBL_W-1:0]         i_class_label,
    input  logic                              i_last_item,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [knn_pkg::LBL_W-1:0]         i_winning_label,
    input  logic [knn_pkg::K_W-1:0]           i_vote_count,
    input  logic signed [knn_pkg::SIM_W-1:0]  i_mean_similarity,
    output int                                o_mismatches,
    output int                                o_outstanding
);
    import knn_pkg::*;

    localparam int TALLY_MAX = 15;

    typedef struct packed {
        logic [LBL_W-1:0]        label;
        logic [K_W-1:0]          votes;
        logic signed [SIM_W-1:0] mean;
    } t_verdict;

    logic [K_W-1:0]          k_reg;
    logic [NCLS_W-1:0]       ncls_reg;
    logic signed [SIM_W-1:0] nb_score  [MAX_K];
    logic [LBL_W-1:0]        nb_class  [MAX_K];
    logic                    nb_filled [MAX_K];
    t_verdict                verdicts_due [$];
    t_verdict                want;
    int                      mismatches = 0;

    task automatic clear_neighbours();
        for (int i = 0; i < MAX_K; i++) begin
            nb_score[i]  = '0;
            nb_class[i]  = '0;
            nb_filled[i] = 1'b0;
        end
    endtask

    task automatic report_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // One scored training item: replace the weakest slot, and on the final item
    // poll the slots and queue the vote.
    task automatic rank_training_item(input logic signed [SIM_W-1:0] sim,
                                      input logic [LBL_W-1:0] lbl, input logic last);
        int       k;
        int       ncls;
        int       low;
        int       best;
        int       sum;
        int       tally [MAX_CLASSES];
        t_verdict v;
        k    = (k_reg == 0) ? 1 : ((k_reg > MAX_K) ? MAX_K : int'(k_reg));
        ncls = (ncls_reg == 0) ? 1 : ((ncls_reg > MAX_CLASSES) ? MAX_CLASSES : int'(ncls_reg));
        low  = 0;
        for (int i = 1; i < k; i++)
            if (nb_score[i] < nb_score[low]) low = i;
        // strictly greater: a score equal to the weakest slot is dropped
        if (sim > nb_score[low]) begin
            nb_score[low]  = sim;
            nb_class[low]  = lbl;
            nb_filled[low] = 1'b1;
        end
        if (last) begin
            sum = 0;
            for (int c = 0; c < MAX_CLASSES; c++) tally[c] = 0;
            for (int i = 0; i < k; i++) begin
                sum += nb_score[i];
                // empty slots and labels beyond the class count do not vote
                if (nb_filled[i] && int'(nb_class[i]) < ncls && tally[nb_class[i]] < TALLY_MAX)
                    tally[nb_class[i]]++;
            end
            best = 0;
            for (int c = 1; c < ncls; c++)
                if (tally[c] > tally[best]) best = c;
            v.label = LBL_W'(best);
            v.votes = K_W'(tally[best]);
            v.mean  = SIM_W'(sum / k);
            verdicts_due = {verdicts_due, v};
            clear_neighbours();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            k_reg    = K_RESET;
            ncls_reg = NCLS_RESET;
            clear_neighbours();
            verdicts_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_K_IN_USE:    k_reg    = i_cfg_data[K_W-1:0];
                    CFG_NUM_CLASSES: ncls_reg = i_cfg_data[NCLS_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual label %0d votes %0d mean %0d",
                             $time, i_winning_label, i_vote_count, i_mean_similarity);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    report_field("winning_label", want.label, i_winning_label);
                    report_field("vote_count", want.votes, i_vote_count);
                    report_field("mean_similarity", int'($signed(want.mean)),
                                 int'(i_mean_similarity));
                end
            end
            if (i_in_valid && i_in_ready)
                rank_training_item(i_similarity, i_class_label, i_last_item);
        end
        o_outstanding <= verdicts_due.size();
        o_mismatches  <= mismatches;
    end

endmodule

FILE: tb/sv/knn_top_k_majority_vote_unit_test.sv
// Top of the k-NN majority vote regression: clock, reset, register writes, request
// stimulus and output back-pressure around the unit and its scoreboard.
// Depends on knn_pkg, knn_top_k_majority_vote_unit and knn_top_k_majority_vote_checker.
module knn_top_k_majority_vote_unit_test;
    import knn_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 48;
    localparam int N_PHASES      = 8;

    typedef enum int {
        PACE_SENDER_LIGHT,
        PACE_RECEIVER_LIGHT,
        PACE_FULL
    } t_pace;

    // a negative k or class count means a random setting
    localparam int    PH_K     [N_PHASES] = '{0, 15, 5, 2, 1, 8, 4, -1};
    localparam int    PH_NCLS  [N_PHASES] = '{0, 127, 10, 2, 1, 64, 33, -1};
    localparam int    PH_ITEMS [N_PHASES] = '{40, 50, 50, 50, 40, 50, 60, 60};
    localparam bit    PH_OPEN  [N_PHASES] = '{1, 0, 1, 0, 1, 0, 0, 0};
    localparam bit    PH_HOLD  [N_PHASES] = '{0, 0, 0, 0, 0, 0, 1, 0};
    localparam t_pace PH_PACE  [N_PHASES] = '{PACE_SENDER_LIGHT, PACE_SENDER_LIGHT,
                                              PACE_SENDER_LIGHT, PACE_RECEIVER_LIGHT,
                                              PACE_RECEIVER_LIGHT, PACE_RECEIVER_LIGHT,
                                              PACE_FULL, PACE_FULL};

    logic                    i_clk             = 1'b0;
    logic                    i_rst_n           = 1'b0;
    logic                    i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx         = '0;
    logic [CFG_W-1:0]        i_cfg_data        = '0;
    logic                    i_in_valid        = 1'b0;
    logic signed [SIM_W-1:0] i_similarity      = '0;
    logic [LBL_W-1:0]        i_class_label     = '0;
    logic                    i_last_item       = 1'b0;
    logic                    i_out_ready       = 1'b0;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic [LBL_W-1:0]        o_winning_label;
    logic [K_W-1:0]          o_vote_count;
    logic signed [SIM_W-1:0] o_mean_similarity;

    int mismatches;
    int outstanding;
    int src_idle_pct = 35;
    int dst_idle_pct = 74;
    int hold_seq     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int cur_ncls     = 64;
    int query_cluster = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    knn_top_k_majority_vote_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_similarity      (i_similarity),
        .i_class_label     (i_class_label),
        .i_last_item       (i_last_item),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_winning_label   (o_winning_label),
        .o_vote_count      (o_vote_count),
        .o_mean_similarity (o_mean_similarity)
    );

    knn_top_k_majority_vote_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_similarity      (i_similarity),
        .i_class_label     (i_class_label),
        .i_last_item       (i_last_item),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_winning_label   (o_winning_label),
        .i_vote_count      (o_vote_count),
        .i_mean_similarity (o_mean_similarity),
        .o_mismatches      (mismatches),
        .o_outstanding     (outstanding)
    );

    // result side: random back-pressure, or a long hold-off when one is asked for
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("knn_top_k_majority_vote_unit regression: fail");
        $finish;
    end

    task automatic send_req(input logic signed [SIM_W-1:0] sim, input logic [LBL_W-1:0] lbl,
                            input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_similarity  <= sim;
        i_class_label <= lbl;
        i_last_item   <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // drain: nothing offered, every vote returned, then the unit's own latency
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    function automatic logic signed [SIM_W-1:0] pick_similarity();
        int r;
        r = $urandom_range(7);
        case (r)
            0: return SIM_W'($urandom());
            1: begin
                case ($urandom_range(4))
                    0: return 16'h8000;
                    1: return 16'hffff;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'h7fff;
                endcase
            end
            2: return SIM_W'(-int'($urandom_range(32768, 1)));
            default: return SIM_W'($urandom_range(32767));
        endcase
    endfunction

    // half the time one of three neighbouring classes so that majorities form
    function automatic logic [LBL_W-1:0] pick_label();
        int span;
        int r;
        span = (cur_ncls == 0) ? 1 : ((cur_ncls > MAX_CLASSES) ? MAX_CLASSES : cur_ncls);
        r = $urandom_range(3);
        if (r == 0) return LBL_W'($urandom_range(63));
        if (r == 1) return LBL_W'($urandom_range(span > 63 ? 63 : span));
        return LBL_W'((query_cluster + $urandom_range(2)) % MAX_CLASSES);
    endfunction

    initial begin
        int k_sel;
        int ncls_sel;
        int sent;
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: three slots, all classes
        src_idle_pct = 35;
        dst_idle_pct = 74;
        send_req(-32768, 0, 1'b0);
        send_req(32767, 63, 1'b0);
        send_req(1, 5, 1'b0);
        send_req(0, 7, 1'b0);
        send_req(32767, 63, 1'b1);
        // a negative score does not beat an empty slot: no votes
        send_req(-1, 9, 1'b0);
        send_req(-32768, 1, 1'b1);
        // equal scores: first weakest slot is replaced
        send_req(100, 2, 1'b0);
        send_req(100, 4, 1'b0);
        send_req(100, 6, 1'b0);
        send_req(100, 8, 1'b0);
        send_req(200, 4, 1'b1);
        send_req(32767, 1, 1'b1);
        send_req(5, 63, 1'b0);
        send_req(6, 63, 1'b0);
        send_req(7, 62, 1'b1);
        send_req(1000, 3, 1'b0);
        send_req(2000, 3, 1'b0);
        send_req(3000, 3, 1'b1);

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            k_sel    = (PH_K[p] < 0) ? $urandom_range(15) : PH_K[p];
            ncls_sel = (PH_NCLS[p] < 0) ? $urandom_range(127) : PH_NCLS[p];
            write_reg(CFG_K_IN_USE, CFG_W'(k_sel));
            write_reg(CFG_NUM_CLASSES, CFG_W'(ncls_sel));
            i_cfg_we <= 1'b0;
            cur_ncls = ncls_sel;
            case (PH_PACE[p])
                PACE_SENDER_LIGHT: begin
                    src_idle_pct = 35;
                    dst_idle_pct = 74;
                end
                PACE_RECEIVER_LIGHT: begin
                    src_idle_pct = 74;
                    dst_idle_pct = 35;
                end
                default: begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase
            if (PH_HOLD[p]) hold_seq <= hold_seq + 1;
            sent = 0;
            while (sent < PH_ITEMS[p]) begin
                if (PH_HOLD[p])
                    len = $urandom_range(2, 1);
                else if ($urandom_range(7) == 0)
                    len = $urandom_range(20, 12);
                else
                    len = $urandom_range(8, 1);
                query_cluster = $urandom_range(MAX_CLASSES - 1);
                // the odd early end makes broken queries
                for (int i = 0; i < len; i++)
                    send_req(pick_similarity(), pick_label(),
                             (i == len - 1) || ($urandom_range(19) == 0));
                sent += len;
            end
            // leave a query open so the next settings apply mid query
            if (PH_OPEN[p])
                repeat ($urandom_range(3, 1)) send_req(pick_similarity(), pick_label(), 1'b0);
        end

        settle();
        if (mismatches == 0)
            $display("knn_top_k_majority_vote_unit regression: pass");
        else
            $display("knn_top_k_majority_vote_unit regression: fail");
        $finish;
    end

endmodule
